/* rtl/cps_pkg.sv */
`timescale 1ns / 1ps

package cps_pkg;

	// default payload limit in bytes
	localparam int unsigned MAX_PAYLOAD_DEFAULT = 512;

	// register reset values
	localparam logic [7:0] LOCAL_NODE_RESET  = 8'd254;
	localparam logic [7:0] TARGET_NODE_RESET = 8'd69;

	// register map
	localparam int unsigned REG_IDX_W = 1;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_LOCAL_NODE  = 1'b0;
	localparam reg_idx_t REG_TARGET_NODE = 1'b1;
	localparam int unsigned APB_ADDR_W = REG_IDX_W + 2;

	// frame kinds carried in can_id bits 15:8
	localparam logic [7:0] FRAME_KIND_FILL      = 8'd5;
	localparam logic [7:0] FRAME_KIND_FILL_LONG = 8'd6;
	localparam logic [7:0] FRAME_KIND_PROCESS   = 8'd7;
	localparam logic [7:0] FRAME_KIND_SHORT     = 8'd8;

	// largest offset that fits the one-byte fill header
	localparam logic [15:0] SHORT_OFFSET_MAX = 16'd255;

	// output packing: can_id, frame_length, frame_bytes, zero pad
	localparam int unsigned TDATA_W = 88;

	// descriptor queue depth
	localparam int unsigned QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [7:0] local_node;
		logic [7:0] target_node;
	} cps_cfg_t;

	typedef enum logic [1:0] {
		DESC_FILL,
		DESC_SHORT,
		DESC_PROCESS,
		DESC_ERROR
	} desc_kind_t;

	// one frame to build; for a process frame data holds count in 15:0, crc in 31:16
	typedef struct packed {
		desc_kind_t  kind;
		logic [15:0] start;
		logic [2:0]  fill;
		logic [55:0] data;
	} cps_desc_t;

	typedef struct packed {
		logic first;
		logic second;
	} cps_push_t;

	// crc-16 xmodem, one byte
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ 16'h1021;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* rtl/cps_front.sv */
`timescale 1ns / 1ps

module cps_front #(
	parameter int unsigned MAX_PAYLOAD = cps_pkg::MAX_PAYLOAD_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	input  logic                space_ok,
	output cps_pkg::cps_push_t  push,
	output cps_pkg::cps_desc_t  desc0,
	output cps_pkg::cps_desc_t  desc1
);

	localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] start_q;
	logic [2:0]       fill_q;
	logic [15:0]      crc_q;
	logic             too_long_q;
	logic [7:0]       chunk_q [7];

	logic             fire;
	logic             overflow;
	logic             drop;
	logic [CNT_W-1:0] cnt_nx;
	logic [2:0]       fill_nx;
	logic [15:0]      crc_nx;
	logic [55:0]      data_nx;
	logic             cap_full;
	logic             is_short;
	cps_pkg::cps_desc_t fill_desc;

	assign in_ready = space_ok;
	assign fire     = in_valid & space_ok;

	// byte bookkeeping
	assign overflow = !too_long_q && (count_q == CNT_W'(MAX_PAYLOAD));
	assign drop     = too_long_q | overflow;
	assign cnt_nx   = count_q + 1'b1;
	assign fill_nx  = fill_q + 3'd1;
	assign crc_nx   = cps_pkg::crc16_byte(crc_q, in_byte);
	assign is_short = 16'(cnt_nx) <= 16'd6;

	// chunk as it stands with this byte added
	always_comb begin
		for (int i = 0; i < 7; i++) begin
			data_nx[8*i +: 8] = (3'(i) == fill_q) ? in_byte : chunk_q[i];
		end
	end

	// chunk full: seven bytes under a one-byte offset, six under a two-byte one
	always_comb begin
		if (16'(start_q) <= cps_pkg::SHORT_OFFSET_MAX) begin
			cap_full = fill_nx == 3'd7;
		end else begin
			cap_full = fill_nx >= 3'd6;
		end
	end

	always_comb begin
		fill_desc.kind  = cps_pkg::DESC_FILL;
		fill_desc.start = 16'(start_q);
		fill_desc.fill  = fill_nx;
		fill_desc.data  = data_nx;
	end

	// classify the byte into zero, one or two frame descriptors
	always_comb begin
		push  = '0;
		desc0 = fill_desc;
		desc1 = '0;
		desc1.kind = cps_pkg::DESC_PROCESS;
		desc1.data = {24'd0, crc_nx, 16'(cnt_nx)};
		if (fire) begin
			if (drop) begin
				if (in_last) begin
					desc0       = '0;
					desc0.kind  = cps_pkg::DESC_ERROR;
					push.first  = 1'b1;
				end
			end else if (in_last) begin
				push.first = 1'b1;
				if (is_short) begin
					desc0.kind = cps_pkg::DESC_SHORT;
				end else begin
					push.second = 1'b1;
				end
			end else if (cap_full) begin
				push.first = 1'b1;
			end
		end
	end

	// payload state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			start_q    <= '0;
			fill_q     <= '0;
			crc_q      <= '0;
			too_long_q <= 1'b0;
		end else if (fire) begin
			if (in_last) begin
				count_q    <= '0;
				start_q    <= '0;
				fill_q     <= '0;
				crc_q      <= '0;
				too_long_q <= 1'b0;
			end else if (drop) begin
				too_long_q <= 1'b1;
			end else begin
				count_q <= cnt_nx;
				crc_q   <= crc_nx;
				if (cap_full) begin
					start_q <= start_q + CNT_W'(fill_nx);
					fill_q  <= '0;
				end else begin
					fill_q <= fill_nx;
				end
			end
		end
	end

	// chunk bytes
	always_ff @(posedge clk) begin
		if (fire && !drop) begin
			chunk_q[fill_q] <= in_byte;
		end
	end

endmodule

/* rtl/cps_queue.sv */
`timescale 1ns / 1ps

module cps_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  cps_pkg::cps_push_t  push,
	input  cps_pkg::cps_desc_t  wr_desc0,
	input  cps_pkg::cps_desc_t  wr_desc1,
	output logic                space_ok,
	output logic                rd_valid,
	input  logic                rd_ready,
	output cps_pkg::cps_desc_t  rd_desc
);

	localparam int unsigned DEPTH = cps_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cps_pkg::cps_desc_t entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	logic [CNT_W-1:0]   wr_n;
	logic               pop;

	// room for a two-frame burst
	assign space_ok = count_q <= CNT_W'(DEPTH - 2);
	assign rd_valid = count_q != '0;
	assign rd_desc  = entry_q[rd_ptr_q];
	assign pop      = rd_valid & rd_ready;
	assign wr_n     = CNT_W'(push.first) + CNT_W'(push.second);

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(wr_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + wr_n - CNT_W'(pop);
		end
	end

	// entries
	always_ff @(posedge clk) begin
		if (push.first) begin
			entry_q[wr_ptr_q] <= wr_desc0;
		end
		if (push.second) begin
			entry_q[wr_ptr_q + 1'b1] <= wr_desc1;
		end
	end

endmodule

/* rtl/cps_back.sv */
`timescale 1ns / 1ps

module cps_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cps_pkg::cps_cfg_t             cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  cps_pkg::cps_desc_t            in_desc,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [cps_pkg::TDATA_W-1:0]   m_tdata,
	output logic                          m_tlast,
	output logic                          m_tuser
);

	logic                        valid_q;
	logic [cps_pkg::TDATA_W-1:0] data_q;
	logic                        last_q;
	logic                        user_q;

	logic        load;
	logic [15:0] can_id;
	logic [3:0]  frame_length;
	logic [63:0] frame_bytes;
	logic        frame_last;
	logic        status;

	assign in_ready = !valid_q | m_tready;
	assign load     = in_valid & in_ready;

	// frame formatting
	always_comb begin
		can_id       = '0;
		frame_length = '0;
		frame_bytes  = '0;
		frame_last   = 1'b0;
		status       = 1'b0;
		case (in_desc.kind)
			cps_pkg::DESC_SHORT: begin
				can_id            = {cps_pkg::FRAME_KIND_SHORT, cfg.target_node};
				frame_length      = 4'(in_desc.fill) + 4'd2;
				frame_bytes[7:0]  = cfg.local_node;
				for (int i = 0; i < 6; i++) begin
					if (3'(i) < in_desc.fill) begin
						frame_bytes[8*(i+2) +: 8] = in_desc.data[8*i +: 8];
					end
				end
				frame_last = 1'b1;
			end
			cps_pkg::DESC_FILL: begin
				if (in_desc.start <= cps_pkg::SHORT_OFFSET_MAX) begin
					can_id           = {cps_pkg::FRAME_KIND_FILL, cfg.target_node};
					frame_length     = 4'(in_desc.fill) + 4'd1;
					frame_bytes[7:0] = in_desc.start[7:0];
					for (int i = 0; i < 7; i++) begin
						if (3'(i) < in_desc.fill) begin
							frame_bytes[8*(i+1) +: 8] = in_desc.data[8*i +: 8];
						end
					end
				end else begin
					can_id            = {cps_pkg::FRAME_KIND_FILL_LONG, cfg.target_node};
					frame_length      = 4'(in_desc.fill) + 4'd2;
					frame_bytes[7:0]  = in_desc.start[15:8];
					frame_bytes[15:8] = in_desc.start[7:0];
					for (int i = 0; i < 6; i++) begin
						if (3'(i) < in_desc.fill) begin
							frame_bytes[8*(i+2) +: 8] = in_desc.data[8*i +: 8];
						end
					end
				end
			end
			cps_pkg::DESC_PROCESS: begin
				can_id       = {cps_pkg::FRAME_KIND_PROCESS, cfg.target_node};
				frame_length = 4'd6;
				frame_bytes  = {16'd0, in_desc.data[23:16], in_desc.data[31:24],
					in_desc.data[7:0], in_desc.data[15:8], 8'd0, cfg.local_node};
				frame_last   = 1'b1;
			end
			cps_pkg::DESC_ERROR: begin
				frame_last = 1'b1;
				status     = 1'b1;
			end
			default: begin
				frame_last = 1'b0;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= {4'd0, frame_bytes, frame_length, can_id};
			last_q <= frame_last;
			user_q <= status;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;
	assign m_tuser  = user_q;

endmodule

/* rtl/can_payload_segmenter.sv */
`timescale 1ns / 1ps
// a frame enters the descriptor queue at the transfer of the byte that causes it and then
// passes through the output register to m_tvalid
// throughput: one payload byte per cycle while s_tready is high; at most one frame leaves per
// cycle, so the two frames that close a long payload leave one after the other
// s_tready drops while the four-entry descriptor queue has fewer than two free entries
// reset: arst_n clears all payload state and the queue; local_node resets to 254, target_node to 69
module can_payload_segmenter #(
	parameter int unsigned MAX_PAYLOAD = cps_pkg::MAX_PAYLOAD_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// apb configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cps_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	// payload in
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,  // payload_byte
	input  logic                            s_tlast,  // last_byte
	// frames out
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [cps_pkg::TDATA_W-1:0]     m_tdata,  // can_id, frame_length, frame_bytes
	output logic                            m_tlast,  // frame_last
	output logic                            m_tuser   // status
);

	logic [7:0]         local_node_q;
	logic [7:0]         target_node_q;
	cps_pkg::reg_idx_t  reg_idx;
	logic               cfg_wr;
	cps_pkg::cps_cfg_t  cfg;

	cps_pkg::cps_push_t push;
	cps_pkg::cps_desc_t desc0;
	cps_pkg::cps_desc_t desc1;
	cps_pkg::cps_desc_t rd_desc;
	logic               space_ok;
	logic               rd_valid;
	logic               rd_ready;

	// register access
	assign pready  = 1'b1;
	assign reg_idx = paddr[cps_pkg::APB_ADDR_W-1:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_node_q  <= cps_pkg::LOCAL_NODE_RESET;
			target_node_q <= cps_pkg::TARGET_NODE_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				cps_pkg::REG_LOCAL_NODE:  local_node_q  <= pwdata[7:0];
				cps_pkg::REG_TARGET_NODE: target_node_q <= pwdata[7:0];
				default: begin
					local_node_q <= local_node_q;
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			cps_pkg::REG_LOCAL_NODE:  prdata = {24'd0, local_node_q};
			cps_pkg::REG_TARGET_NODE: prdata = {24'd0, target_node_q};
			default:                  prdata = '0;
		endcase
	end

	assign cfg.local_node  = local_node_q;
	assign cfg.target_node = target_node_q;

	// byte intake and classification
	cps_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.space_ok (space_ok),
		.push     (push),
		.desc0    (desc0),
		.desc1    (desc1)
	);

	// descriptor queue
	cps_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_desc0 (desc0),
		.wr_desc1 (desc1),
		.space_ok (space_ok),
		.rd_valid (rd_valid),
		.rd_ready (rd_ready),
		.rd_desc  (rd_desc)
	);

	// frame building and output
	cps_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (rd_valid),
		.in_ready (rd_ready),
		.in_desc  (rd_desc),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

	localparam int unsigned PAYLOAD_MAX   = cps_pkg::MAX_PAYLOAD_DEFAULT;
	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned LOUD_ERRORS   = 10;

	typedef struct packed {
		logic [15:0] can_id;
		logic [3:0]  len;
		logic [63:0] data;
		logic        last;
		logic        status;
	} frame_t;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
		logic       typed;
		frame_t     exp;
	} plan_row_t;

	localparam frame_t NO_FRAME = '0;

	// directed payloads: single bytes at both extremes, the longest short frame,
	// the shortest segmented payload, and one that spills a byte into a second fill
	localparam plan_row_t PLAN [23] = '{
		'{8'hFF, 1'b1, 1'b1, '{16'h0845, 4'd3, 64'h0000_0000_00FF_00FE, 1'b1, 1'b0}},
		'{8'h00, 1'b1, 1'b1, '{16'h0845, 4'd3, 64'h0000_0000_0000_00FE, 1'b1, 1'b0}},
		'{8'h01, 1'b0, 1'b0, NO_FRAME},
		'{8'h02, 1'b0, 1'b0, NO_FRAME},
		'{8'h04, 1'b0, 1'b0, NO_FRAME},
		'{8'h08, 1'b0, 1'b0, NO_FRAME},
		'{8'h10, 1'b0, 1'b0, NO_FRAME},
		'{8'h20, 1'b1, 1'b1, '{16'h0845, 4'd8, 64'h2010_0804_0201_00FE, 1'b1, 1'b0}},
		'{8'h80, 1'b0, 1'b0, NO_FRAME},
		'{8'h40, 1'b0, 1'b0, NO_FRAME},
		'{8'h20, 1'b0, 1'b0, NO_FRAME},
		'{8'h10, 1'b0, 1'b0, NO_FRAME},
		'{8'h08, 1'b0, 1'b0, NO_FRAME},
		'{8'h04, 1'b0, 1'b0, NO_FRAME},
		'{8'h02, 1'b1, 1'b0, NO_FRAME},
		'{8'hAA, 1'b0, 1'b0, NO_FRAME},
		'{8'h55, 1'b0, 1'b0, NO_FRAME},
		'{8'hF0, 1'b0, 1'b0, NO_FRAME},
		'{8'h0F, 1'b0, 1'b0, NO_FRAME},
		'{8'hC3, 1'b0, 1'b0, NO_FRAME},
		'{8'h3C, 1'b0, 1'b0, NO_FRAME},
		'{8'h7E, 1'b0, 1'b0, NO_FRAME},
		'{8'h81, 1'b1, 1'b0, NO_FRAME}
	};

	logic                            clk;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [cps_pkg::APB_ADDR_W-1:0]  paddr;
	logic [31:0]                     pwdata;
	logic [31:0]                     prdata;
	logic                            pready;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [7:0]                      s_tdata;  // payload_byte
	logic                            s_tlast;  // last_byte
	logic                            m_tvalid;
	logic                            m_tready;
	logic [cps_pkg::TDATA_W-1:0]     m_tdata;  // can_id, frame_length, frame_bytes
	logic                            m_tlast;  // frame_last
	logic                            m_tuser;  // status

	// shadow registers and segmentation state
	logic [7:0]  cfg_local;
	logic [7:0]  cfg_target;
	logic [15:0] seg_count;
	logic [7:0]  seg_chunk [7];
	logic [2:0]  seg_fill;
	logic [15:0] seg_start;
	logic [15:0] seg_crc;
	logic        seg_overflow;

	frame_t frames_due [$];
	int     mismatch_count = 0;
	int     cycle_count = 0;
	int     send_idle = 20;
	int     recv_idle = 70;
	int     hold_req = 0;
	int     hold_seen = 0;
	int     hold_left = 0;

	can_payload_segmenter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic log_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= LOUD_ERRORS) begin
			$display("%s", msg);
		end
	endtask

	// crc-16 xmodem, one input bit at a time, msb first
	function automatic logic [15:0] xmodem_next(input logic [15:0] c, input logic [7:0] b);
		logic fb;
		for (int k = 7; k >= 0; k--) begin
			fb = c[15] ^ b[k];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ 16'h1021;
			end
		end
		return c;
	endfunction

	function automatic void clear_segment();
		seg_count = '0;
		seg_fill = '0;
		seg_start = '0;
		seg_crc = '0;
		seg_overflow = 1'b0;
		for (int i = 0; i < 7; i++) begin
			seg_chunk[i] = '0;
		end
	endfunction

	function automatic frame_t make_frame(input logic [7:0] kind, input logic [3:0] len,
			input logic [63:0] data, input logic last);
		frame_t f;
		f.can_id = {kind, cfg_target};
		f.len = len;
		f.data = data;
		f.last = last;
		f.status = 1'b0;
		return f;
	endfunction

	// flush the partial chunk as a fill frame and move the offset on
	function automatic frame_t take_fill();
		logic [63:0] d;
		int          hdr;
		logic [7:0]  kind;
		frame_t      f;
		d = '0;
		if (seg_start <= cps_pkg::SHORT_OFFSET_MAX) begin
			d[7:0] = seg_start[7:0];
			hdr = 1;
			kind = cps_pkg::FRAME_KIND_FILL;
		end else begin
			d[7:0] = seg_start[15:8];
			d[15:8] = seg_start[7:0];
			hdr = 2;
			kind = cps_pkg::FRAME_KIND_FILL_LONG;
		end
		for (int i = 0; i < seg_fill; i++) begin
			d[8*(hdr+i) +: 8] = seg_chunk[i];
		end
		f = make_frame(kind, 4'(hdr + seg_fill), d, 1'b0);
		seg_start = seg_start + 16'(seg_fill);
		seg_fill = '0;
		return f;
	endfunction

	// frames caused by one payload byte
	function automatic int segment_byte(input logic [7:0] b, input logic last,
			output frame_t r0, output frame_t r1);
		logic [16:0] nxt;
		logic [63:0] d;
		int          n;
		n = 0;
		r0 = '0;
		r1 = '0;
		if (!seg_overflow) begin
			nxt = {1'b0, seg_count} + 17'd1;
			if (nxt > PAYLOAD_MAX) begin
				seg_overflow = 1'b1;
			end else begin
				seg_count = nxt[15:0];
				seg_crc = xmodem_next(seg_crc, b);
				if (seg_fill < 3'd7) begin
					seg_chunk[seg_fill] = b;
				end
				seg_fill++;
			end
		end

		// overlong payload: bytes past the limit dropped, no closing frames, one error result at the end
		if (seg_overflow) begin
			if (last) begin
				r0.last = 1'b1;
				r0.status = 1'b1;
				n = 1;
				clear_segment();
			end
			return n;
		end

		if (last) begin
			d = '0;
			d[7:0] = cfg_local;
			if (seg_count <= 16'd6) begin
				for (int i = 0; i < seg_fill; i++) begin
					d[8*(2+i) +: 8] = seg_chunk[i];
				end
				r0 = make_frame(cps_pkg::FRAME_KIND_SHORT, 4'(2 + seg_fill), d, 1'b1);
				n = 1;
			end else begin
				r0 = take_fill();
				d[23:16] = seg_count[15:8];
				d[31:24] = seg_count[7:0];
				d[39:32] = seg_crc[15:8];
				d[47:40] = seg_crc[7:0];
				r1 = make_frame(cps_pkg::FRAME_KIND_PROCESS, 4'd6, d, 1'b1);
				n = 2;
			end
			clear_segment();
			return n;
		end

		// chunk full: one-byte offset holds 7 bytes, two-byte offset 6
		if (seg_fill >= ((seg_start <= cps_pkg::SHORT_OFFSET_MAX) ? 3'd7 : 3'd6)) begin
			r0 = take_fill();
			n = 1;
		end
		return n;
	endfunction

	// payload byte transfer with random gaps ahead of it
	task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
			input frame_t typed_frame);
		frame_t r0, r1;
		int     n;
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		n = segment_byte(b, last, r0, r1);
		if (typed) begin
			frames_due.push_back(typed_frame);
		end else begin
			if (n > 0) frames_due.push_back(r0);
			if (n > 1) frames_due.push_back(r1);
		end
	endtask

	task automatic send_payload(input int len);
		for (int i = 0; i < len; i++) begin
			send_byte(8'($urandom_range(255)), i == len - 1, 1'b0, NO_FRAME);
		end
	endtask

	// mostly short and medium payloads with random content
	task automatic random_traffic(input int budget);
		int sent;
		int len;
		sent = 0;
		while (sent < budget) begin
			case ($urandom_range(9)) inside
				[0:3]: len = $urandom_range(1, 6);
				[4:7]: len = $urandom_range(7, 40);
				8: len = 1;
				default: len = $urandom_range(41, 80);
			endcase
			send_payload(len);
			sent += len;
		end
	endtask

	// stop offering and wait until every frame is out and the block is quiet
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (frames_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write with junk above the 8 register bits
	task automatic reg_write(input cps_pkg::reg_idx_t idx, input logic [7:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == cps_pkg::REG_LOCAL_NODE) begin
			cfg_local = value;
		end else begin
			cfg_target = value;
		end
	endtask

	task automatic reg_read(input cps_pkg::reg_idx_t idx, input logic [7:0] want);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {24'h0, want}) begin
			log_mismatch($sformatf("register %0d read: expected %h, got %h",
				idx, {24'h0, want}, prdata));
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// frame check against the oldest expectation
	always @(posedge clk) begin
		frame_t got;
		frame_t want;
		if (m_tvalid && m_tready) begin
			got.can_id = m_tdata[15:0];
			got.len = m_tdata[19:16];
			got.data = m_tdata[83:20];
			got.last = m_tlast;
			got.status = m_tuser;
			if (frames_due.size() == 0) begin
				log_mismatch($sformatf("unexpected frame id %h len %0d data %h last %b status %b",
					got.can_id, got.len, got.data, got.last, got.status));
			end else begin
				want = frames_due.pop_front();
				if (got.can_id !== want.can_id || got.len !== want.len ||
						got.data !== want.data || got.last !== want.last ||
						got.status !== want.status) begin
					log_mismatch($sformatf({
						"frame mismatch: expected id %h len %0d data %h last %b status %b\n",
						"                got      id %h len %0d data %h last %b status %b"},
						want.can_id, want.len, want.data, want.last, want.status,
						got.can_id, got.len, got.data, got.last, got.status));
				end
			end
		end
	end

	// main sequence
	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_local = cps_pkg::LOCAL_NODE_RESET;
		cfg_target = cps_pkg::TARGET_NODE_RESET;
		clear_segment();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset values, then the directed payloads
		reg_read(cps_pkg::REG_LOCAL_NODE, 8'd254);
		reg_read(cps_pkg::REG_TARGET_NODE, 8'd69);
		foreach (PLAN[i]) begin
			send_byte(PLAN[i].b, PLAN[i].last, PLAN[i].typed, PLAN[i].exp);
		end
		drain();

		// lowest local id, highest target
		reg_write(cps_pkg::REG_LOCAL_NODE, 8'h00);
		reg_write(cps_pkg::REG_TARGET_NODE, 8'hFF);
		reg_read(cps_pkg::REG_LOCAL_NODE, 8'h00);
		reg_read(cps_pkg::REG_TARGET_NODE, 8'hFF);
		random_traffic(20);
		drain();

		// swap the idling sides, opposite extremes, an overlong payload that runs
		// through the full length and the two-byte offsets first
		send_idle = 70;
		recv_idle = 20;
		reg_write(cps_pkg::REG_LOCAL_NODE, 8'hFF);
		reg_write(cps_pkg::REG_TARGET_NODE, 8'h00);
		reg_read(cps_pkg::REG_LOCAL_NODE, 8'hFF);
		reg_read(cps_pkg::REG_TARGET_NODE, 8'h00);
		random_traffic(10);
		send_payload(PAYLOAD_MAX + 1 + $urandom_range(4));
		drain();

		// no idling, random ids, receiver holds off so the input backs up
		send_idle = 0;
		recv_idle = 0;
		reg_write(cps_pkg::REG_LOCAL_NODE, 8'($urandom_range(255)));
		reg_write(cps_pkg::REG_TARGET_NODE, 8'($urandom_range(255)));
		reg_read(cps_pkg::REG_LOCAL_NODE, cfg_local);
		reg_read(cps_pkg::REG_TARGET_NODE, cfg_target);
		hold_req++;
		repeat (12) send_payload(1);
		random_traffic(30);
		drain();

		if (mismatch_count == 0 && frames_due.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
